FILE: design/sorted_set_insert_delete_unit_macros.svh
// Assertion macros for the sorted set unit.
// Define NO_ASSERTIONS to compile them away.
`ifndef SORTED_SET_INSERT_DELETE_UNIT_MACROS_SVH
`define SORTED_SET_INSERT_DELETE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that cons holds in the same cycle as ante.
`define SSID_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define SSID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SSID_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define SSID_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: design/ssid_pkg.sv
package ssid_pkg;

   localparam int VALUE_W  = 32;
   localparam int POS_W    = 6;
   localparam int FILL_W   = 7;
   localparam int STATUS_W = 2;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_DELETE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE   = 2'd0,
      ST_FULL   = 2'd1,
      ST_DUP    = 2'd2,
      ST_ABSENT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_EVAL,
      PH_COMMIT
   } phase_type;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      logic capture;
      logic shift_up;
      logic shift_down;
   } cell_ctrl_type;

endpackage

FILE: design/ssid_req_if.sv
interface ssid_req_if;
   import ssid_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink (input valid, input kind, input value, output ready);
endinterface

FILE: design/ssid_rsp_if.sv
interface ssid_rsp_if;
   import ssid_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [POS_W-1:0]    position;
   logic [FILL_W-1:0]   fill_count;

   modport source (output valid, output status, output position, output fill_count,
                   input ready);
   modport sink (input valid, input status, input position, input fill_count,
                 output ready);
endinterface

FILE: design/ssid_cell.sv
module ssid_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  logic                               clock,
   input  ssid_pkg::cell_ctrl_type            ctrl,
   input  logic [CNT_W-1:0]                   count,
   input  logic signed [ssid_pkg::VALUE_W-1:0] value,
   input  logic signed [ssid_pkg::VALUE_W-1:0] left_entry,
   input  logic                               left_lt,
   input  logic                               left_occ,
   input  logic signed [ssid_pkg::VALUE_W-1:0] right_entry,
   output logic signed [ssid_pkg::VALUE_W-1:0] entry,
   output logic                               lt,
   output logic                               occ,
   output logic                               eq,
   output logic [ssid_pkg::POS_W-1:0]         pos_code
);
   import ssid_pkg::*;

   logic signed [VALUE_W-1:0] entry_ff, entry_in;
   logic                      lt_ff, lt_in;
   logic                      eq_ff, eq_in;
   logic                      boundary;

   assign occ      = CNT_W'(INDEX) < count;
   // first cell not below the value: insert gap or the matching entry
   assign boundary = !lt_ff && left_lt;

   always_comb begin
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      entry_in = entry_ff;
      if (ctrl.capture) begin
         lt_in = occ && (entry_ff < value);
         eq_in = occ && (entry_ff == value);
      end
      if (ctrl.shift_up) begin
         if (left_occ && !left_lt) begin
            entry_in = left_entry;
         end else if (boundary) begin
            entry_in = value;
         end
      end
      if (ctrl.shift_down && occ && !lt_ff) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
   end

   assign entry    = entry_ff;
   assign lt       = lt_ff;
   assign eq       = eq_ff;
   assign pos_code = boundary ? POS_W'(INDEX) : '0;
endmodule

FILE: design/sorted_set_insert_delete_unit.sv
// Sorted set unit: insert and delete of signed 32-bit values in a row of cells.
// An accepted word is latched, compared in EVAL, its result registered at COMMIT.
// A new word can be taken in the cycle the current one commits; a stalled result
// holds the commit step and with it the next word.
// Reset (synchronous, active high) empties the set and clears the handshake state;
// entry contents stay undefined until written.
`include "sorted_set_insert_delete_unit_macros.svh"

module sorted_set_insert_delete_unit #(
   parameter int CAPACITY = 64
) (
   input logic       clock,
   input logic       reset,
   ssid_req_if.sink  req_chan,
   ssid_rsp_if.source rsp_chan
);
   import ssid_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Sequencer: IDLE waits for a word, EVAL lets every cell compare its entry
   // with the latched value, COMMIT shifts the row and loads the result.
   phase_type phase_ff, phase_in;

   // latched command word
   logic                      kind_ff, kind_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;

   logic [CNT_W-1:0] count_ff, count_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]    rsp_position_ff, rsp_position_in;
   logic [FILL_W-1:0]   rsp_fill_ff, rsp_fill_in;

   logic          req_fire;
   logic          commit_fire;
   logic          full;
   logic          found;
   logic [POS_W-1:0] position;
   cell_ctrl_type ctrl;

   // per-cell neighbor taps
   logic signed [VALUE_W-1:0] entry_w [CAPACITY];
   logic                      lt_w    [CAPACITY];
   logic                      occ_w   [CAPACITY];
   logic [CAPACITY-1:0]       eq_w;
   logic [POS_W-1:0]          code_w  [CAPACITY];

   // Commit only when the output register is free or being emptied this cycle.
   assign commit_fire = (phase_ff == PH_COMMIT) && (!rsp_valid_ff || rsp_chan.ready);
   // Take a new word when idle, or in the cycle the current one commits; its
   // compare step then sees the updated row.
   assign req_chan.ready = (phase_ff == PH_IDLE) || commit_fire;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign full  = count_ff == CNT_W'(CAPACITY);
   assign found = |eq_w;

   // At most one cell marks the boundary, so an OR of the codes gives its index.
   always_comb begin
      position = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         position = position | code_w[i];
      end
   end

   always_comb begin
      ctrl.capture    = phase_ff == PH_EVAL;
      ctrl.shift_up   = commit_fire && (kind_ff == KIND_INSERT) && !full && !found;
      ctrl.shift_down = commit_fire && (kind_ff == KIND_DELETE) && found;
   end

   // Cell chain: each cell sees its left neighbor's entry and flags for the
   // upward shift and its right neighbor's entry for the downward shift.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] left_entry;
      logic                      left_lt;
      logic                      left_occ;
      logic signed [VALUE_W-1:0] right_entry;

      if (i == 0) begin : g_first
         // an imaginary cell below the row: always below the value, never shifts in
         assign left_entry = '0;
         assign left_lt    = 1'b1;
         assign left_occ   = 1'b0;
      end else begin : g_inner
         assign left_entry = entry_w[i-1];
         assign left_lt    = lt_w[i-1];
         assign left_occ   = occ_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_mid
         assign right_entry = entry_w[i+1];
      end

      ssid_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .count       (count_ff),
         .value       (value_ff),
         .left_entry  (left_entry),
         .left_lt     (left_lt),
         .left_occ    (left_occ),
         .right_entry (right_entry),
         .entry       (entry_w[i]),
         .lt          (lt_w[i]),
         .occ         (occ_w[i]),
         .eq          (eq_w[i]),
         .pos_code    (code_w[i])
      );
   end

   // Next state, command latch, count and result.
   always_comb begin
      phase_in        = phase_ff;
      kind_in         = kind_ff;
      value_in        = value_ff;
      count_in        = count_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_position_in = rsp_position_ff;
      rsp_fill_in     = rsp_fill_ff;

      // drop the result once taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_fire) begin
         kind_in  = req_chan.kind;
         value_in = req_chan.value;
      end

      unique case (phase_ff)
         PH_IDLE: begin
            if (req_fire) begin
               phase_in = PH_EVAL;
            end
         end
         PH_EVAL: begin
            phase_in = PH_COMMIT;
         end
         PH_COMMIT: begin
            if (commit_fire) begin
               phase_in = req_fire ? PH_EVAL : PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      if (commit_fire) begin
         rsp_valid_in    = 1'b1;
         rsp_position_in = '0;
         if (kind_ff == KIND_INSERT) begin
            if (full) begin
               rsp_status_in = ST_FULL;
            end else if (found) begin
               rsp_status_in = ST_DUP;
            end else begin
               rsp_status_in   = ST_DONE;
               rsp_position_in = position;
               count_in        = count_ff + 1'b1;
            end
         end else begin
            if (found) begin
               rsp_status_in   = ST_DONE;
               rsp_position_in = position;
               count_in        = count_ff - 1'b1;
            end else begin
               rsp_status_in = ST_ABSENT;
            end
         end
         rsp_fill_in = FILL_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      kind_ff         <= kind_in;
      value_ff        <= value_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_position_ff <= rsp_position_in;
      rsp_fill_ff     <= rsp_fill_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.position   = rsp_position_ff;
   assign rsp_chan.fill_count = rsp_fill_ff;

   // Checks on the sequencer and the fill count.
   `SSID_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `SSID_ASSERT_NEXT(a_eval_to_commit, clock, reset, phase_ff == PH_EVAL, phase_ff == PH_COMMIT, "compare step not followed by commit")
   `SSID_ASSERT_NEXT(a_commit_result, clock, reset, commit_fire, rsp_valid_ff, "commit without result")
   `SSID_ASSERT_NEXT(a_insert_count, clock, reset, ctrl.shift_up, count_ff == $past(count_ff) + 1'b1, "insert did not grow the set")
endmodule
